>>> src/prss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prss_pkg
// shared widths, register indexes and defaults for the residual square sum
// ----------------------------------------------------------------------------
package prss_pkg;

	localparam int DATA_W    = 32;
	localparam int SUM_W     = 63;
	localparam int COUNT_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int MUL_W     = DATA_W + 1;
	localparam int PROD_W    = 2 * MUL_W;

	localparam int DEF_MAX_COEFS = 6;
	localparam int DEF_FRAC_BITS = 16;

	// register indexes of the write port
	localparam logic [CFG_IDX_W-1:0] REG_COEF_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0     = 3'd1;

	localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

	typedef logic signed [MUL_W-1:0]  mul_opd_t;
	typedef logic signed [PROD_W-1:0] mul_prod_t;

endpackage

>>> src/prss_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prss_mul
// shared signed 33x33 multiplier with a registered product
// ----------------------------------------------------------------------------
module prss_mul (
	input  logic               clk,
	input  logic               en,
	input  prss_pkg::mul_opd_t opd_a,
	input  prss_pkg::mul_opd_t opd_b,
	output prss_pkg::mul_prod_t prod_s1
);
	import prss_pkg::*;

	mul_prod_t prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(opd_a) * PROD_W'(opd_b);
		end
	end

	assign prod_s1 = prod_q;

endmodule

>>> src/polynomial_residual_square_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_residual_square_sum
// horner polynomial fit with a running saturating sum of squared residuals
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one beat of x_value, observed
//   and last, all signed fixed point with FRAC_BITS fraction bits
//   output channel (out_valid/out_ready) gives one beat per input beat:
//   model_value, the running square_sum, the sticky overflow and set_done
//   configuration is a plain write port (cfg_we, cfg_index, cfg_data):
//   index 0 is the coefficient count, 1..6 are coef_0..coef_5
// timing
//   one shared multiplier serves every horner step and the final square
//   an item runs a multiply and add step pair for each coefficient below
//   the top one, then the residual, square, accumulate and output steps
//   the next beat is taken at the earliest in the cycle after the load,
//   so no new beat is taken before the last one is in the output register
//   in_ready is high only while the sequencer is idle
// reset and stall
//   arst_n clears coefficients, count, running sum and overflow flag
//   the output register holds a result until taken; the sequencer waits
//   in its output step while a previous beat is still pending
//   a beat with last set closes the set and the sum and flag then clear
// ----------------------------------------------------------------------------
module polynomial_residual_square_sum #(
	parameter int MAX_COEFS = prss_pkg::DEF_MAX_COEFS,
	parameter int FRAC_BITS = prss_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [prss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [prss_pkg::DATA_W-1:0]       cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [prss_pkg::DATA_W-1:0] x_value,
	input  logic signed [prss_pkg::DATA_W-1:0] observed,
	input  logic                              last,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [prss_pkg::DATA_W-1:0] model_value,
	output logic [prss_pkg::SUM_W-1:0]        square_sum,
	output logic                              overflow,
	output logic                              set_done
);
	import prss_pkg::*;

	localparam int IDX_W = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;

	// one-hot sequencer
	typedef enum logic [6:0] {
		ST_IDLE = 7'b000_0001,
		ST_MUL  = 7'b000_0010,
		ST_ADD  = 7'b000_0100,
		ST_RES  = 7'b000_1000,
		ST_SQ   = 7'b001_0000,
		ST_ACC  = 7'b010_0000,
		ST_OUT  = 7'b100_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [COUNT_W-1:0]       count_q;
	logic signed [DATA_W-1:0] coef_q [MAX_COEFS];

	// item held while the sequencer works on it
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] obs_q;
	logic                     last_q;
	logic signed [DATA_W-1:0] acc_q;
	logic [IDX_W-1:0]         step_q;
	logic                     sat_q;
	logic signed [MUL_W-1:0]  r_q;

	// running set state
	logic [SUM_W-1:0] sum_q;
	logic             sticky_q;

	// output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] model_q;
	logic [SUM_W-1:0]         ssum_q;
	logic                     ovf_q;
	logic                     done_q;

	logic [COUNT_W-1:0]       n_use;
	logic [IDX_W-1:0]         rd_idx;
	logic signed [DATA_W-1:0] coef_rd;
	logic                     accept;
	logic                     out_free;

	mul_opd_t  opd_a;
	mul_opd_t  opd_b;
	mul_prod_t prod_s1;
	logic      mul_en;

	logic signed [PROD_W-1:0] p_shift;
	logic [PROD_W-1:0]        h_sum;
	logic                     h_hi;
	logic                     h_lo;
	logic signed [DATA_W-1:0] h_acc;

	logic [SUM_W:0]   sq_w;
	logic [SUM_W:0]   sum_w;
	logic             sum_sat;
	logic [SUM_W-1:0] sum_new;

	// coefficient count clipped to what the block stores
	assign n_use = (count_q > COUNT_W'(MAX_COEFS)) ? COUNT_W'(MAX_COEFS) : count_q;

	// single read port on the coefficient bank: top coefficient on accept,
	// next lower one during the horner add
	assign rd_idx  = (state_q == ST_IDLE) ? IDX_W'(n_use - COUNT_W'(1)) :
	                                         (step_q - IDX_W'(1));
	assign coef_rd = coef_q[rd_idx];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// multiplier operands: acc * x for horner, r * r for the square
	always_comb begin
		if (state_q == ST_SQ) begin
			opd_a = r_q;
			opd_b = r_q;
		end else begin
			opd_a = {acc_q[DATA_W-1], acc_q};
			opd_b = {x_q[DATA_W-1], x_q};
		end
	end

	assign mul_en = (state_q == ST_MUL) || (state_q == ST_SQ);

	prss_mul u_mul (
		.clk     (clk),
		.en      (mul_en),
		.opd_a   (opd_a),
		.opd_b   (opd_b),
		.prod_s1 (prod_s1)
	);

	// horner step: round half up, add coefficient, clamp to 32 bits
	// the rounding bit rides in as a carry so this is one add
	assign p_shift = prod_s1 >>> FRAC_BITS;
	assign h_sum   = p_shift + {{(PROD_W-DATA_W){coef_rd[DATA_W-1]}}, coef_rd}
	                 + PROD_W'(prod_s1[FRAC_BITS-1]);
	assign h_hi    = !h_sum[PROD_W-1] && (|h_sum[PROD_W-2:DATA_W-1]);
	assign h_lo    = h_sum[PROD_W-1] && !(&h_sum[PROD_W-2:DATA_W-1]);

	always_comb begin
		priority if (h_hi) begin
			h_acc = S32_MAX;
		end else if (h_lo) begin
			h_acc = S32_MIN;
		end else begin
			h_acc = h_sum[DATA_W-1:0];
		end
	end

	// squared residual back to FRAC_BITS fraction bits, then accumulate
	// the square is never negative and fits in the low 64 product bits
	assign sq_w    = (prod_s1[SUM_W:0] >> FRAC_BITS) + (SUM_W+1)'(prod_s1[FRAC_BITS-1]);
	assign sum_w   = {1'b0, sum_q} + sq_w;
	assign sum_sat = sum_w[SUM_W];
	assign sum_new = sum_sat ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < MAX_COEFS; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_COEF_COUNT) begin
				count_q <= cfg_data[COUNT_W-1:0];
			end
			// write indexes above MAX_COEFS reach no coefficient slot
			for (int k = 0; k < MAX_COEFS; k++) begin
				if (cfg_index == REG_COEF_0 + CFG_IDX_W'(k)) begin
					coef_q[k] <= cfg_data;
				end
			end
		end
	end

	// sequencer and running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			sat_q    <= 1'b0;
			sum_q    <= '0;
			sticky_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sat_q <= 1'b0;
						if (n_use == '0) begin
							step_q  <= '0;
							state_q <= ST_RES;
						end else begin
							step_q  <= IDX_W'(n_use - COUNT_W'(1));
							state_q <= (n_use > COUNT_W'(1)) ? ST_MUL : ST_RES;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sat_q   <= sat_q | h_hi | h_lo;
					step_q  <= step_q - IDX_W'(1);
					state_q <= (step_q > IDX_W'(1)) ? ST_MUL : ST_RES;
				end
				ST_RES: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q    <= sum_new;
					sticky_q <= sticky_q | sat_q | sum_sat;
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						// a closing beat clears the set once its result is loaded
						if (last_q) begin
							sum_q    <= '0;
							sticky_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= x_value;
			obs_q  <= observed;
			last_q <= last;
			acc_q  <= (n_use == '0) ? '0 : coef_rd;
		end else if (state_q == ST_ADD) begin
			acc_q <= h_acc;
		end
		if (state_q == ST_RES) begin
			r_q <= {obs_q[DATA_W-1], obs_q} - {acc_q[DATA_W-1], acc_q};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			model_q <= acc_q;
			ssum_q  <= sum_q;
			ovf_q   <= sticky_q;
			done_q  <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign model_value = model_q;
	assign square_sum  = ssum_q;
	assign overflow    = ovf_q;
	assign set_done    = done_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_add_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> (step_q != '0))
		else $error("horner add with no coefficient left");

	a_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && out_free && last_q) |=> ((sum_q == '0) && !sticky_q))
		else $error("set state not cleared after closing beat");

	a_sticky_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sticky_q) |-> $past((state_q == ST_OUT) && last_q))
		else $error("overflow flag dropped inside a set");
`endif

endmodule
